>>> hdl/assert_macros.svh
// Assertion macros used by note_song_stream_parser_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assert failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assert failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

>>> hdl/nsp_pkg.sv
//------------------------------------------------------------------------------
// nsp_pkg
// Types and constants for the song stream parser.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package nsp_pkg;
   localparam logic [2:0] KIND_FIELD = 3'd0;
   localparam logic [2:0] KIND_STRING = 3'd1;
   localparam logic [2:0] KIND_NOTE = 3'd2;
   localparam logic [2:0] KIND_END = 3'd3;
   localparam logic [2:0] KIND_ERROR = 3'd4;
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_TRUNC = 2'd1;
   localparam logic [1:0] ERR_BADLEN = 2'd2;
   localparam logic [4:0] PH_TICK = 5'd22;
   localparam logic [4:0] PH_LAYER = 5'd23;
   localparam logic [4:0] PH_INST = 5'd24;
   localparam logic [4:0] PH_PITCH = 5'd28;

   typedef struct packed {
      logic [7:0] data_byte;
      logic end_of_file;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [4:0] field_index;
      logic [31:0] field_value;
      logic signed [31:0] note_tick;
      logic [7:0] instrument;
      logic [7:0] note_key;
      logic [7:0] velocity;
      logic [7:0] panning;
      logic signed [15:0] fine_pitch;
      logic [1:0] error_code;
   } rsp_type;

   function automatic logic [2:0] field_size(input logic [4:0] ph);
      logic [2:0] s;
      case (ph)
         5'd1, 5'd2, 5'd10, 5'd11, 5'd12, 5'd19, 5'd20,
         5'd24, 5'd25, 5'd26, 5'd27: s = 3'd1;
         5'd5, 5'd6, 5'd7, 5'd8, 5'd13, 5'd14, 5'd15, 5'd16,
         5'd17, 5'd18: s = 3'd4;
         default: s = 3'd2;
      endcase
      return s;
   endfunction

   function automatic logic is_string(input logic [4:0] ph);
      return (ph >= 5'd5 && ph <= 5'd8) || ph == 5'd18;
   endfunction
endpackage
`default_nettype wire

>>> hdl/nsp_if.sv
//------------------------------------------------------------------------------
// nsp_req_if / nsp_rsp_if
// Valid/ready channels for requests and responses.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface nsp_req_if;
   logic valid;
   logic ready;
   nsp_pkg::req_type req_data;
   modport source(output valid, output req_data, input ready);
   modport sink(input valid, input req_data, output ready);
endinterface

interface nsp_rsp_if;
   logic valid;
   logic ready;
   nsp_pkg::rsp_type rsp_data;
   modport source(output valid, output rsp_data, input ready);
   modport sink(input valid, input rsp_data, output ready);
endinterface
`default_nettype wire

>>> hdl/note_song_stream_parser_top.sv
//------------------------------------------------------------------------------
// note_song_stream_parser_top
// Streaming parser for note-block song files.
//------------------------------------------------------------------------------
// Usage: the song file enters on req_ one byte per transfer, end_of_file
// marking the last byte. Results leave on rsp_: header fields, string
// bytes, notes, song end or an error, at most one per byte.
// A result is offered in the cycle after its byte is taken.
// Throughput: one byte per cycle while the queue can take a result; the
// parser state is registered and a two-entry queue decouples it from the result port.
// Reset clears parser state and the queue; the tick starts at -1.
// When the receiver stalls the queue fills and req_ready drops once it
// holds two results and no result is taken in that cycle.
// After a song end or an error, later bytes are taken and dropped.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module note_song_stream_parser_top (
   input wire logic clock,
   input wire logic reset,
   nsp_req_if.sink req,
   nsp_rsp_if.source rsp
);
   logic can_push, push;
   logic push_err;
   nsp_pkg::rsp_type push_data;

   nsp_front u_front (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_data(req.req_data),
      .can_push(can_push), .in_ready(req.ready), .push(push), .push_data(push_data)
   );

   nsp_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data),
      .can_push(can_push), .out_valid(rsp.valid), .out_data(rsp.rsp_data),
      .out_ready(rsp.ready)
   );

   assign push_err = push && push_data.kind == nsp_pkg::KIND_ERROR;

   `ASSERT_IMPLIES(a_push_ready, clock, reset, push, req.ready && req.valid)
   `ASSERT_IMPLIES(a_err_code, clock, reset, push_err, push_data.error_code != nsp_pkg::ERR_NONE)
   `ASSERT_NEXT(a_push_shows, clock, reset, push, rsp.valid)
endmodule
`default_nettype wire

>>> hdl/nsp_front.sv
//------------------------------------------------------------------------------
// nsp_front
// Parses one byte per transfer and produces at most one result per byte.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nsp_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   input wire nsp_pkg::req_type in_data,
   input wire logic can_push,
   output logic in_ready,
   output logic push,
   output nsp_pkg::rsp_type push_data
);
   logic [4:0] phase_ff, phase_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [31:0] word_ff, word_in;
   logic [30:0] srem_ff, srem_in;
   logic [31:0] tick_ff, tick_in;
   logic [31:0] note_ff, note_in;
   logic stop_ff, stop_in;
   logic [31:0] v;
   logic [2:0] nb;
   nsp_pkg::rsp_type r;
   logic have;
   logic fire;

   assign in_ready = can_push;
   assign fire = in_valid && can_push;

   always_comb begin
      phase_in = phase_ff; cnt_in = cnt_ff; word_in = word_ff; srem_in = srem_ff;
      tick_in = tick_ff; note_in = note_ff; stop_in = stop_ff;
      r = '0; have = 1'b0;
      v = word_ff | ({24'd0, in_data.data_byte} << {cnt_ff, 3'b000});
      nb = {1'b0, cnt_ff} + 3'd1;
      if (stop_ff) begin
      end else if (srem_ff != '0) begin
         r.kind = nsp_pkg::KIND_STRING; r.field_index = phase_ff;
         r.field_value = {24'd0, in_data.data_byte}; have = 1'b1;
         srem_in = srem_ff - 31'd1;
         if (srem_ff == 31'd1) phase_in = phase_ff + 5'd1;
      end else if (phase_ff > nsp_pkg::PH_PITCH) begin
         stop_in = 1'b1;
      end else if (nb < nsp_pkg::field_size(phase_ff)) begin
         word_in = v; cnt_in = nb[1:0];
      end else begin
         word_in = '0; cnt_in = '0;
         if (phase_ff < nsp_pkg::PH_TICK) begin
            if (nsp_pkg::is_string(phase_ff) && v[31]) begin
               r.kind = nsp_pkg::KIND_ERROR; r.error_code = nsp_pkg::ERR_BADLEN;
               have = 1'b1; stop_in = 1'b1;
            end else begin
               r.kind = nsp_pkg::KIND_FIELD; r.field_index = phase_ff;
               r.field_value = v; have = 1'b1;
               if (nsp_pkg::is_string(phase_ff) && v != '0) srem_in = v[30:0];
               else phase_in = phase_ff + 5'd1;
            end
         end else if (phase_ff == nsp_pkg::PH_TICK) begin
            if (v[15:0] == '0) begin
               r.kind = nsp_pkg::KIND_END; have = 1'b1; stop_in = 1'b1;
            end else begin
               tick_in = tick_ff + {{16{v[15]}}, v[15:0]};
               phase_in = nsp_pkg::PH_LAYER;
            end
         end else if (phase_ff == nsp_pkg::PH_LAYER) begin
            phase_in = (v[15:0] == '0) ? nsp_pkg::PH_TICK : nsp_pkg::PH_INST;
         end else if (phase_ff < nsp_pkg::PH_PITCH) begin
            case (phase_ff[1:0])
               2'd0: note_in[7:0] = v[7:0];
               2'd1: note_in[15:8] = v[7:0];
               2'd2: note_in[23:16] = v[7:0];
               default: note_in[31:24] = v[7:0];
            endcase
            phase_in = phase_ff + 5'd1;
         end else begin
            r.kind = nsp_pkg::KIND_NOTE; r.note_tick = tick_ff;
            r.instrument = note_ff[7:0]; r.note_key = note_ff[15:8];
            r.velocity = note_ff[23:16]; r.panning = note_ff[31:24];
            r.fine_pitch = v[15:0]; have = 1'b1; phase_in = nsp_pkg::PH_LAYER;
         end
      end
      if (!stop_ff && in_data.end_of_file && !(have && r.kind != nsp_pkg::KIND_FIELD
            && r.kind != nsp_pkg::KIND_STRING && r.kind != nsp_pkg::KIND_NOTE)) begin
         r = '0; r.kind = nsp_pkg::KIND_ERROR; r.error_code = nsp_pkg::ERR_TRUNC;
         have = 1'b1; stop_in = 1'b1;
      end
   end

   assign push = fire && have;
   assign push_data = r;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0; cnt_ff <= '0; word_ff <= '0; srem_ff <= '0;
         tick_ff <= '1; note_ff <= '0; stop_ff <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in; cnt_ff <= cnt_in; word_ff <= word_in;
         srem_ff <= srem_in; tick_ff <= tick_in; note_ff <= note_in;
         stop_ff <= stop_in;
      end
   end
endmodule
`default_nettype wire

>>> hdl/nsp_queue.sv
//------------------------------------------------------------------------------
// nsp_queue
// Two-entry result queue between the parser and the output port.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nsp_queue (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire nsp_pkg::rsp_type push_data,
   output logic can_push,
   output logic out_valid,
   output nsp_pkg::rsp_type out_data,
   input wire logic out_ready
);
   nsp_pkg::rsp_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic pop;

   assign out_valid = cnt_ff != 2'd0;
   assign out_data = mem_ff[rp_ff];
   assign pop = out_valid && out_ready;
   assign can_push = cnt_ff != 2'd2 || out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

>>> test/tb_note_song_stream_parser_top.sv
//------------------------------------------------------------------------------
// tb_note_song_stream_parser_top
// Streams one song file through the parser: header fields and strings with
// edge values or a header cut short by a bad string length, directed and
// random ticks and notes, a long result stall, then a song end or truncation.
// Every result is checked against an in-bench parser model, field by field, in order.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_note_song_stream_parser_top;
   import nsp_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT = 5000;
   localparam int RANDOM_BYTES = 1230;
   localparam int FIELD_BYTES [0:28] = '{2, 1, 1, 2, 2, 4, 4, 4, 4, 2, 1, 1, 1, 4, 4,
                                          4, 4, 4, 4, 1, 1, 2, 2, 2, 1, 1, 1, 1, 2};

   logic clock = 1'b0;
   logic reset = 1'b1;

   nsp_req_if req ();
   nsp_rsp_if rsp ();

   note_song_stream_parser_top dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // parser model state
   int phase;
   int nbytes;
   logic [31:0] word;
   logic [30:0] str_left;
   logic [31:0] tick_now;
   logic [7:0] n_inst, n_key, n_vel, n_pan;
   bit halted;

   rsp_type parsed_results[$];
   int errors = 0;
   int bytes_sent = 0;
   bit quiet = 1'b0;
   bit hold_req = 1'b0;
   int idle_cycles = 0;

   function automatic bit holds_string(input int ph);
      return (ph >= 5 && ph <= 8) || ph == 18;
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, input logic e, output rsp_type r);
      logic [31:0] v;
      bit got;
      got = 1'b0;
      r = '0;
      if (halted) return 1'b0;
      if (str_left != 0) begin
         r.kind = KIND_STRING;
         r.field_index = phase[4:0];
         r.field_value = {24'd0, b};
         got = 1'b1;
         str_left = str_left - 1;
         if (str_left == 0) phase++;
      end else begin
         word = word | ({24'd0, b} << (8 * nbytes));
         nbytes++;
         if (nbytes >= FIELD_BYTES[phase]) begin
            v = word;
            word = '0;
            nbytes = 0;
            if (phase < PH_TICK) begin
               if (holds_string(phase) && v[31]) begin
                  r.kind = KIND_ERROR;
                  r.error_code = ERR_BADLEN;
                  halted = 1'b1;
                  return 1'b1;
               end
               r.kind = KIND_FIELD;
               r.field_index = phase[4:0];
               r.field_value = v;
               got = 1'b1;
               if (holds_string(phase) && v != 0) str_left = v[30:0];
               else phase++;
            end else if (phase == PH_TICK) begin
               if (v == 0) begin
                  r.kind = KIND_END;
                  halted = 1'b1;
                  return 1'b1;
               end
               tick_now = tick_now + {{16{v[15]}}, v[15:0]};
               phase = PH_LAYER;
            end else if (phase == PH_LAYER) begin
               phase = (v == 0) ? PH_TICK : PH_INST;
            end else if (phase < PH_PITCH) begin
               case (phase - PH_INST)
                  0: n_inst = v[7:0];
                  1: n_key = v[7:0];
                  2: n_vel = v[7:0];
                  default: n_pan = v[7:0];
               endcase
               phase++;
            end else begin
               r.kind = KIND_NOTE;
               r.note_tick = tick_now;
               r.instrument = n_inst;
               r.note_key = n_key;
               r.velocity = n_vel;
               r.panning = n_pan;
               r.fine_pitch = v[15:0];
               got = 1'b1;
               phase = PH_LAYER;
            end
         end
      end
      if (e) begin
         r = '0;
         r.kind = KIND_ERROR;
         r.error_code = ERR_TRUNC;
         halted = 1'b1;
         return 1'b1;
      end
      return got;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic e);
      int gap;
      rsp_type r;
      gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.req_data <= '{data_byte: b, end_of_file: e};
      do @(posedge clock); while (!req.ready);
      if (parse_byte(b, e, r)) parsed_results.push_back(r);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_word(input logic [31:0] v, input int n, input logic e_last = 1'b0);
      for (int i = 0; i < n; i++) send_byte(v[8 * i +: 8], e_last && i == n - 1);
   endtask

   task automatic send_tick(input logic [15:0] jump, input int layers, input bit extremes);
      send_word(jump, 2);
      for (int i = 0; i < layers; i++) begin
         send_word(extremes ? (i[0] ? 16'hFFFF : 16'h0001) : $urandom_range(1, 65535), 2);
         if (extremes) begin
            send_word(i[0] ? 32'hFFFF_FFFF : 32'h0000_0000, 4);
            send_word(i[0] ? 16'h8000 : 16'h7FFF, 2);
         end else begin
            send_word($urandom, 4);
            send_word($urandom_range(0, 65535), 2);
         end
      end
      send_word(16'h0000, 2);
   endtask

   // header with edge-valued fields; returns 1 if it ended on a bad length
   task automatic test_header(input bit bad_len, output bit stopped);
      int bad_field;
      int len;
      logic [31:0] v;
      stopped = 1'b0;
      bad_field = 5 + $urandom_range(0, 4);
      if (bad_field == 9) bad_field = 18;
      for (int f = 0; f < 22; f++) begin
         if (holds_string(f)) begin
            if (bad_len && f == bad_field) begin
               send_word(32'h8000_0000 | $urandom, 4, $urandom_range(0, 1));
               stopped = 1'b1;
               return;
            end
            len = (f == 5) ? 0 : $urandom_range(1, 5);
            send_word(len, 4);
            for (int i = 0; i < len; i++)
               send_byte(i == 0 ? 8'hFF : (i == 1 ? 8'h00 : $urandom_range(0, 255)), 1'b0);
         end else begin
            v = (f % 3 == 0) ? 32'hFFFF_FFFF : (f % 3 == 1 ? 32'd0 : $urandom);
            send_word(v, FIELD_BYTES[f]);
         end
      end
   endtask

   task automatic test_directed_notes();
      send_tick(16'h7FFF, 2, 1'b1);
      send_tick(16'h8000, 1, 1'b1);
      send_tick(16'h0001, 0, 1'b0);
   endtask

   task automatic test_random_ticks();
      int start;
      bit held;
      start = bytes_sent;
      held = 1'b0;
      while (bytes_sent - start < RANDOM_BYTES) begin
         if ($urandom_range(0, 7) == 0) quiet = !quiet;
         if (!held && bytes_sent - start > 400) begin
            hold_req = 1'b1;
            held = 1'b1;
         end
         send_tick(($urandom_range(0, 5) == 0) ? $urandom_range(1, 65535) :
                   $urandom_range(1, 4), $urandom_range(0, 4), 1'b0);
      end
      quiet = 1'b0;
   endtask

   task automatic test_termination(input int mode);
      logic [7:0] tail [0:8];
      int cut;
      case (mode)
         0: send_word(16'h0000, 2, 1'b1);
         1: send_word(16'h0000, 2);
         default: begin
            tail[0] = 8'h05; tail[1] = 8'h00; tail[2] = 8'h02; tail[3] = 8'h00;
            for (int i = 4; i < 9; i++) tail[i] = $urandom_range(0, 255);
            cut = $urandom_range(1, 9);
            for (int i = 0; i < cut; i++) send_byte(tail[i], i == cut - 1);
         end
      endcase
   endtask

   task automatic test_ignored_bytes();
      repeat (12) send_byte($urandom_range(0, 255), $urandom_range(0, 1));
   endtask

   // result receiver
   initial begin
      int stall;
      rsp.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            stall = quiet ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
               rsp.ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         @(negedge clock);
      end
   end

   task automatic mismatch(input string name, input logic [31:0] exp, input logic [31:0] act);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp, act);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_type exp;
      rsp_type act;
      if (!reset && rsp.valid && rsp.ready) begin
         act = rsp.rsp_data;
         if (parsed_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d", $realtime,
                     act.kind);
            errors++;
         end else begin
            exp = parsed_results.pop_front();
            if (act.kind !== exp.kind) mismatch("kind", exp.kind, act.kind);
            if (act.field_index !== exp.field_index)
               mismatch("field_index", exp.field_index, act.field_index);
            if (act.field_value !== exp.field_value)
               mismatch("field_value", exp.field_value, act.field_value);
            if (act.note_tick !== exp.note_tick)
               mismatch("note_tick", exp.note_tick, act.note_tick);
            if (act.instrument !== exp.instrument)
               mismatch("instrument", exp.instrument, act.instrument);
            if (act.note_key !== exp.note_key) mismatch("note_key", exp.note_key, act.note_key);
            if (act.velocity !== exp.velocity) mismatch("velocity", exp.velocity, act.velocity);
            if (act.panning !== exp.panning) mismatch("panning", exp.panning, act.panning);
            if (act.fine_pitch !== exp.fine_pitch)
               mismatch("fine_pitch", exp.fine_pitch, act.fine_pitch);
            if (act.error_code !== exp.error_code)
               mismatch("error_code", exp.error_code, act.error_code);
         end
      end
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      bit stopped;
      int mode;
      req.valid = 1'b0;
      req.req_data = '0;
      phase = 0; nbytes = 0; word = '0; str_left = '0; tick_now = 32'hFFFF_FFFF;
      n_inst = '0; n_key = '0; n_vel = '0; n_pan = '0; halted = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      mode = $urandom_range(0, 5);
      test_header(mode == 5, stopped);
      if (!stopped) begin
         test_directed_notes();
         test_random_ticks();
         test_termination(mode % 3);
      end
      test_ignored_bytes();
      req.valid <= 1'b0;
      while (parsed_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
